@@ sv/ojq_pkg.sv @@
// Shared types, codes and sizes for the ordered job queue.
package ojq_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_BITS    = 16;
  localparam int HANDLE_BITS = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);

  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [IDX_W-1:0]       index_t;

  typedef enum logic [1:0] {
    KIND_INSERT       = 2'd0,
    KIND_REMOVE_FRONT = 2'd1,
    KIND_REMOVE_KEY   = 2'd2,
    KIND_NONE         = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic    fire;
    logic    insert;
    logic    rm_front;
    logic    rm_key;
    key_t    key;
    handle_t handle;
  } cmd_t;

endpackage

@@ sv/ojq_cell.sv @@
// One queue slot: holds an entry, matches it and shifts forward on removal.
module ojq_cell import ojq_pkg::*; (
  input  logic    clk,
  input  cmd_t    cmd,
  input  logic    occupied,
  input  logic    is_front,
  input  logic    write_here,
  input  logic    take_in,
  input  key_t    next_key,
  input  handle_t next_handle,
  output logic    take_out,
  output logic    sel,
  output key_t    key,
  output handle_t handle
);

  logic match;

  assign match = occupied && ((cmd.rm_key && (key == cmd.key)) || (cmd.rm_front && is_front));
  assign sel      = match && !take_in;
  assign take_out = take_in || match;

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      if (cmd.insert && write_here) begin
        key    <= cmd.key;
        handle <= cmd.handle;
      end else if (take_out) begin
        key    <= next_key;
        handle <= next_handle;
      end
    end
  end

endmodule

@@ sv/ordered_job_queue_remove_by_key.sv @@
// Ordered job queue with insert at rear, front removal and keyed removal.
// Flow: the command register loads on acceptance, then the cell row acts and the output
// register loads. Throughput: one request per cycle while out_stall does not hold the
// output; the row of cells searches and closes the gap as the output register loads.
// Reset clears the count and the valid flags; stored entries are undefined until written.
module ordered_job_queue_remove_by_key import ojq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] job_key,
  input  logic [31:0] payload_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] out_key,
  output logic [31:0] out_handle,
  output logic [3:0]  out_position,
  output logic [4:0]  new_count
);

  logic    cmd_valid;
  kind_t   cmd_kind;
  key_t    cmd_key;
  handle_t cmd_handle;
  count_t  count;
  count_t  count_next;
  logic    exec;
  logic    insert_ok;
  logic    found;
  cmd_t    cmd;

  logic    [DEPTH-1:0] take;
  logic    [DEPTH-1:0] sel;
  key_t    cell_key    [DEPTH];
  handle_t cell_handle [DEPTH];

  key_t    pick_key;
  handle_t pick_handle;
  index_t  pick_pos;

  status_t     status_next;
  logic [15:0] out_key_next;
  logic [31:0] out_handle_next;
  logic [3:0]  out_position_next;

  assign exec     = cmd_valid && (!out_valid || !out_stall);
  assign in_stall = cmd_valid && !exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      cmd_valid <= 1'b1;
    end else if (exec) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_kind   <= kind_t'(kind);
      cmd_key    <= KEY_BITS'(job_key);
      cmd_handle <= HANDLE_BITS'(payload_handle);
    end
  end

  assign insert_ok = (cmd_kind == KIND_INSERT) && (count != count_t'(DEPTH));

  always_comb begin
    cmd.fire     = exec;
    cmd.insert   = insert_ok;
    cmd.rm_front = (cmd_kind == KIND_REMOVE_FRONT);
    cmd.rm_key   = (cmd_kind == KIND_REMOVE_KEY);
    cmd.key      = cmd_key;
    cmd.handle   = cmd_handle;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic    take_in;
    key_t    nk;
    handle_t nh;
    if (i == 0) begin : g_first
      assign take_in = 1'b0;
    end else begin : g_rest
      assign take_in = take[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign nk = cell_key[i];
      assign nh = cell_handle[i];
    end else begin : g_mid
      assign nk = cell_key[i+1];
      assign nh = cell_handle[i+1];
    end
    ojq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (count_t'(i) < count),
      .is_front    (i == 0),
      .write_here  (count == count_t'(i)),
      .take_in     (take_in),
      .next_key    (nk),
      .next_handle (nh),
      .take_out    (take[i]),
      .sel         (sel[i]),
      .key         (cell_key[i]),
      .handle      (cell_handle[i])
    );
  end

  assign found = take[DEPTH-1];

  always_comb begin
    pick_key    = '0;
    pick_handle = '0;
    pick_pos    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        pick_key    = pick_key | cell_key[i];
        pick_handle = pick_handle | cell_handle[i];
        pick_pos    = pick_pos | index_t'(i);
      end
    end
  end

  always_comb begin
    count_next        = count;
    status_next       = ST_MISS;
    out_key_next      = '0;
    out_handle_next   = '0;
    out_position_next = '0;
    if (cmd_kind == KIND_INSERT) begin
      out_key_next = 16'(cmd_key);
      if (insert_ok) begin
        status_next       = ST_OK;
        out_position_next = 4'(count);
        count_next        = count + count_t'(1);
      end else begin
        status_next = ST_FULL;
      end
    end else if (found) begin
      status_next       = ST_OK;
      out_key_next      = 16'(pick_key);
      out_handle_next   = 32'(pick_handle);
      out_position_next = 4'(pick_pos);
      count_next        = count - count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (exec) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status       <= status_next;
      out_key      <= out_key_next;
      out_handle   <= out_handle_next;
      out_position <= out_position_next;
      new_count    <= 5'(count_next);
    end
  end

endmodule
